/* rtl/smpg_pkg.sv */
// shared types and constants of the stepper move pulse generator
package smpg_pkg;

	localparam logic [1:0] FUNC_TICK       = 2'd0;
	localparam logic [1:0] FUNC_MOVE_TIME  = 2'd1;
	localparam logic [1:0] FUNC_MOVE_SPEED = 2'd2;
	localparam logic [1:0] FUNC_RSVD       = 2'd3;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	localparam int unsigned US_PER_MS        = 1000;
	localparam int unsigned US_PER_S         = 1000000;
	// bits of the largest duration in microseconds
	localparam int unsigned DUR_US_W         = 26;
	localparam int unsigned MIN_INTERVAL_RST = 100;

	typedef struct packed {
		logic ld_in;
		logic tick_add;
		logic tick_step;
		logic tick_fix;
		logic mv_setup;
		logic div_start;
		logic int_max;
		logic int_sat;
		logic mv_apply;
		logic out_load;
	} smpg_cmd_t;

	typedef struct packed {
		logic running;
		logic same_pos;
		logic spd_zero;
		logic div_done;
		logic out_free;
	} smpg_sts_t;

endpackage

/* rtl/smpg_div.sv */
// restoring divider, one quotient bit per cycle
module smpg_div
	import smpg_pkg::*;
#(
	parameter int NUM_W = 34,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign done = busy_q && (cnt_q == CNT_W'(1));
	assign quot = quo_q;

endmodule

/* rtl/smpg_ctrl.sv */
// controller state machine of the stepper move pulse generator
module smpg_ctrl
	import smpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] func,
	output logic       in_stall,
	input  smpg_sts_t  sts,
	output smpg_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_TICK_ADD  = 4'd1;
	localparam logic [3:0] S_TICK_STEP = 4'd2;
	localparam logic [3:0] S_TICK_FIX  = 4'd3;
	localparam logic [3:0] S_MV_SETUP  = 4'd4;
	localparam logic [3:0] S_DIV       = 4'd5;
	localparam logic [3:0] S_MV_SAT    = 4'd6;
	localparam logic [3:0] S_MV_APPLY  = 4'd7;
	localparam logic [3:0] S_DONE      = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					unique case (func) inside
						FUNC_TICK:                       state_nxt = sts.running ? S_TICK_ADD : S_DONE;
						FUNC_MOVE_TIME, FUNC_MOVE_SPEED: state_nxt = S_MV_SETUP;
						default:                         state_nxt = S_DONE;
					endcase
				end
			end
			S_TICK_ADD: begin
				cmd.tick_add = 1'b1;
				state_nxt    = S_TICK_STEP;
			end
			S_TICK_STEP: begin
				cmd.tick_step = 1'b1;
				state_nxt     = S_TICK_FIX;
			end
			S_TICK_FIX: begin
				cmd.tick_fix = 1'b1;
				state_nxt    = S_DONE;
			end
			S_MV_SETUP: begin
				cmd.mv_setup = 1'b1;
				if (sts.same_pos) begin
					state_nxt = S_MV_APPLY;
				end else if (sts.spd_zero) begin
					cmd.int_max = 1'b1;
					state_nxt   = S_MV_APPLY;
				end else begin
					cmd.div_start = 1'b1;
					state_nxt     = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done)
					state_nxt = S_MV_SAT;
			end
			S_MV_SAT: begin
				cmd.int_sat = 1'b1;
				state_nxt   = S_MV_APPLY;
			end
			S_MV_APPLY: begin
				cmd.mv_apply = 1'b1;
				state_nxt    = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

/* rtl/smpg_dpath.sv */
// datapath: position, interval, elapsed time, divider and output register
module smpg_dpath
	import smpg_pkg::*;
#(
	parameter int POSITION_WIDTH     = 32,
	parameter int INTERVAL_FRAC_BITS = 8,
	parameter int INTERVAL_WIDTH     = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smpg_cmd_t          cmd,
	output smpg_sts_t          sts,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic [1:0]         func,
	input  logic signed [31:0] target_position,
	input  logic [15:0]        duration_ms,
	input  logic [15:0]        speed_steps_per_s,
	input  logic               clear_finished,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               step_pulse,
	output logic               direction_up,
	output logic               running,
	output logic               finished,
	output logic signed [31:0] current_position,
	output logic signed [31:0] active_target
);

	localparam int PW    = POSITION_WIDTH;
	localparam int FB    = INTERVAL_FRAC_BITS;
	localparam int IW    = INTERVAL_WIDTH;
	localparam int NUM_W = DUR_US_W + FB;
	localparam int DEN_W = (PW > 16) ? PW : 16;
	localparam int SAT_W = (NUM_W > IW) ? NUM_W : IW;

	localparam logic [IW-1:0]    IMAX        = {IW{1'b1}};
	localparam logic [SAT_W-1:0] IMAX_EXT    = SAT_W'(IMAX);
	localparam logic [SAT_W-1:0] MIN_RST_EXT = SAT_W'(MIN_INTERVAL_RST) << FB;
	localparam logic [IW-1:0]    MIN_RST     =
		(MIN_RST_EXT > IMAX_EXT) ? IMAX : MIN_RST_EXT[IW-1:0];
	localparam logic [IW:0]      TICK_INC    = (IW+1)'(1) << FB;

	// latched input item
	logic [1:0]    func_q;
	logic [PW-1:0] tgt_in_q;
	logic [15:0]   dur_q;
	logic [15:0]   spd_q;
	logic          clr_q;

	// block state
	logic [IW-1:0] minv_q;
	logic [PW-1:0] position_q;
	logic [PW-1:0] target_q;
	logic [IW-1:0] interval_q;
	logic [IW-1:0] elapsed_q;
	logic [1:0]    dir_q;
	logic          running_q;
	logic          done_q;
	logic          pulse_q;

	// output register
	logic          out_valid_q;
	logic          step_pulse_q;
	logic          direction_up_q;
	logic          running_out_q;
	logic          finished_q;
	logic [31:0]   cur_pos_q;
	logic [31:0]   act_tgt_q;

	logic [63:0]      tp64;
	logic [63:0]      pos64;
	logic [63:0]      tgt64;
	logic [SAT_W-1:0] cfg_min_ext;
	logic             lt_in;
	logic             lt_tgt;
	logic [PW-1:0]    span;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [NUM_W-1:0] div_quot;
	logic [SAT_W-1:0] quot_ext;
	logic [IW:0]      elapsed_sum;
	logic [IW-1:0]    int_clamped;
	logic             at_target;

	assign tp64        = 64'(target_position);
	assign pos64       = 64'(position_q);
	assign tgt64       = 64'(target_q);
	assign cfg_min_ext = SAT_W'(cfg_wr_data) << FB;
	assign lt_in       = $signed(position_q) < $signed(tgt_in_q);
	assign lt_tgt      = $signed(position_q) < $signed(target_q);
	assign span        = lt_in ? (tgt_in_q - position_q) : (position_q - tgt_in_q);
	assign div_num     = (func_q == FUNC_MOVE_SPEED) ? (NUM_W'(US_PER_S) << FB)
		: (NUM_W'(dur_q * US_PER_MS) << FB);
	assign div_den     = (func_q == FUNC_MOVE_SPEED) ? DEN_W'(spd_q) : DEN_W'(span);
	assign quot_ext    = SAT_W'(div_quot);
	assign elapsed_sum = {1'b0, elapsed_q} + TICK_INC;
	assign int_clamped = (interval_q < minv_q) ? minv_q : interval_q;
	assign at_target   = (position_q == target_q);

	smpg_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			func_q   <= func;
			tgt_in_q <= tp64[PW-1:0];
			dur_q    <= duration_ms;
			spd_q    <= speed_steps_per_s;
			clr_q    <= clear_finished;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minv_q     <= MIN_RST;
			position_q <= '0;
			target_q   <= '0;
			interval_q <= '0;
			elapsed_q  <= '0;
			dir_q      <= DIR_NONE;
			running_q  <= 1'b0;
			done_q     <= 1'b0;
			pulse_q    <= 1'b0;
		end else begin
			if (cfg_wr_en)
				minv_q <= (cfg_min_ext > IMAX_EXT) ? IMAX : cfg_min_ext[IW-1:0];
			if (cmd.ld_in)
				pulse_q <= 1'b0;
			if (cmd.tick_add)
				elapsed_q <= elapsed_sum[IW] ? IMAX : elapsed_sum[IW-1:0];
			if (cmd.tick_step && (elapsed_q >= interval_q)) begin
				if (dir_q == DIR_UP)
					position_q <= position_q + PW'(1);
				else if (dir_q == DIR_DOWN)
					position_q <= position_q - PW'(1);
				pulse_q   <= 1'b1;
				elapsed_q <= elapsed_q - interval_q;
			end
			if (cmd.tick_fix) begin
				// still behind after the step
				if (pulse_q && (elapsed_q >= interval_q))
					elapsed_q <= '0;
				if (at_target) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
			if (cmd.mv_setup)
				target_q <= tgt_in_q;
			if (cmd.int_max)
				interval_q <= IMAX;
			if (cmd.int_sat)
				interval_q <= (quot_ext > IMAX_EXT) ? IMAX : quot_ext[IW-1:0];
			if (cmd.mv_apply) begin
				if (!at_target) begin
					interval_q <= int_clamped;
					elapsed_q  <= int_clamped;
					dir_q      <= lt_tgt ? DIR_UP : DIR_DOWN;
					running_q  <= 1'b1;
				end else begin
					interval_q <= '0;
					dir_q      <= DIR_NONE;
					if (running_q) begin
						running_q <= 1'b0;
						done_q    <= 1'b1;
					end
				end
			end
			if (cmd.out_load && clr_q)
				done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			step_pulse_q   <= pulse_q;
			direction_up_q <= (dir_q == DIR_UP);
			running_out_q  <= running_q;
			finished_q     <= done_q;
			cur_pos_q      <= pos64[31:0];
			act_tgt_q      <= tgt64[31:0];
		end
	end

	assign sts.running  = running_q;
	assign sts.same_pos = (tgt_in_q == position_q);
	assign sts.spd_zero = (func_q == FUNC_MOVE_SPEED) && (spd_q == 16'd0);
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid        = out_valid_q;
	assign step_pulse       = step_pulse_q;
	assign direction_up     = direction_up_q;
	assign running          = running_out_q;
	assign finished         = finished_q;
	assign current_position = cur_pos_q;
	assign active_target    = act_tgt_q;

endmodule

/* rtl/stepper_move_pulse_generator.sv */
// top level of the stepper move pulse generator
// Each input transfer gives exactly one result transfer. A tick while stopped
// goes straight to the output; a tick while running passes through add, step,
// behind check and output. A move command forms its step interval with the
// one-bit-per-cycle divider; a move to the current position or at speed zero
// skips the divider. The block holds one item at a time and takes the next
// one as soon as its result sits in the output register, even while that
// result is still stalled. Write min_step_interval_us only while idle.
module stepper_move_pulse_generator
	import smpg_pkg::*;
#(
	parameter int POSITION_WIDTH     = 32,
	parameter int INTERVAL_FRAC_BITS = 8,
	parameter int INTERVAL_WIDTH     = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [31:0] target_position,
	input  logic [15:0]        duration_ms,
	input  logic [15:0]        speed_steps_per_s,
	input  logic               clear_finished,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               step_pulse,
	output logic               direction_up,
	output logic               running,
	output logic               finished,
	output logic signed [31:0] current_position,
	output logic signed [31:0] active_target
);

	smpg_cmd_t cmd;
	smpg_sts_t sts;

	smpg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.func    (func),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	smpg_dpath #(
		.POSITION_WIDTH    (POSITION_WIDTH),
		.INTERVAL_FRAC_BITS(INTERVAL_FRAC_BITS),
		.INTERVAL_WIDTH    (INTERVAL_WIDTH)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.func             (func),
		.target_position  (target_position),
		.duration_ms      (duration_ms),
		.speed_steps_per_s(speed_steps_per_s),
		.clear_finished   (clear_finished),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.step_pulse       (step_pulse),
		.direction_up     (direction_up),
		.running          (running),
		.finished         (finished),
		.current_position (current_position),
		.active_target    (active_target)
	);

endmodule

/* rtl/smpg_checker.sv */
// port-level assertions of the stepper move pulse generator and their bind
module smpg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               step_pulse,
	input logic               running,
	input logic               finished,
	input logic signed [31:0] current_position,
	input logic signed [31:0] active_target
);

	// one item in flight: an accepted transfer blocks the input next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

	// a step comes only from a running move, which may just have finished
	a_pulse_when_moving: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_pulse |-> running || finished)
		else $error("step pulse without a move");

	// a running move is never at its target
	a_running_off_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && running |-> current_position != active_target)
		else $error("running while at target");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(current_position)
			&& $stable(active_target))
		else $error("stalled result changed");

endmodule

bind stepper_move_pulse_generator smpg_checker u_smpg_checker (.*);
